// ===== rtl/cldp_pkg.sv =====
// cldp_pkg: shared types and constants of the command line decimal parser
// token format between front and back, result format, command codes
// no dependencies
package cldp_pkg;

  localparam int CHAR_W       = 8;
  localparam int CMD_W        = 3;
  localparam int CNT_W        = 3;
  localparam int ARG_W        = 32;
  localparam int NUM_OUT_ARGS = 4;
  localparam int NEED_W       = 4;
  localparam int TERM_W       = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int DIGIT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TERM_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_ROWS = 1'd1;

  localparam logic [TERM_W-1:0] TERM_COLS_RST = 16'd80;
  localparam logic [TERM_W-1:0] TERM_ROWS_RST = 16'd24;
  localparam logic [TERM_W-1:0] MIN_BOARD_COLS = 16'd120;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;

  localparam logic [CMD_W-1:0] CMD_P = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_I = 3'd2;
  localparam logic [CMD_W-1:0] CMD_F = 3'd3;
  localparam logic [CMD_W-1:0] CMD_G = 3'd4;
  localparam logic [CMD_W-1:0] CMD_Q = 3'd5;
  localparam logic [CMD_W-1:0] CMD_M = 3'd6;
  localparam logic [CMD_W-1:0] CMD_B = 3'd7;

  typedef enum logic [2:0] {
    TK_LETTER,
    TK_SPACE,
    TK_DIGIT,
    TK_NEWLINE,
    TK_OTHER
  } tok_cls_t;

  typedef struct packed {
    tok_cls_t             cls;
    logic [CMD_W-1:0]     code;
    logic [DIGIT_W-1:0]   digit;
  } token_t;

  typedef struct packed {
    logic                                line_valid;
    logic [CMD_W-1:0]                    command_code;
    logic [CNT_W-1:0]                    arg_count;
    logic [NUM_OUT_ARGS-1:0][ARG_W-1:0]  args;
  } result_t;

  typedef struct packed {
    logic [TERM_W-1:0] cols;
    logic [TERM_W-1:0] rows;
  } term_cfg_t;

  function automatic logic [NEED_W-1:0] need_count(input logic [CMD_W-1:0] code);
    logic [NEED_W-1:0] n;
    case (code)
      CMD_P:  n = 4'd0;
      CMD_BB: n = 4'd4;
      CMD_I:  n = 4'd4;
      CMD_F:  n = 4'd1;
      CMD_G:  n = 4'd3;
      CMD_Q:  n = 4'd1;
      CMD_M:  n = 4'd3;
      CMD_B:  n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/cldp_fifo.sv =====
// cldp_fifo: two-entry queue with push/full and pop/empty sides
// generic payload width; no dependencies
module cldp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== rtl/cldp_front.sv =====
// cldp_front: accepts characters, classifies them into tokens and queues them
// depends on cldp_pkg and cldp_fifo
module cldp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic [cldp_pkg::CHAR_W-1:0]  in_char_in,
  output logic                         in_full,
  output cldp_pkg::token_t             tok,
  output logic                         tok_empty,
  input  logic                         tok_pop
);

  cldp_pkg::token_t              tok_in;
  logic [$bits(cldp_pkg::token_t)-1:0] tok_raw;
  logic [cldp_pkg::CHAR_W-1:0]   dig_off;

  assign dig_off = in_char_in - cldp_pkg::CH_ZERO;

  always_comb begin
    tok_in.code  = cldp_pkg::CMD_P;
    tok_in.digit = dig_off[cldp_pkg::DIGIT_W-1:0];
    tok_in.cls   = cldp_pkg::TK_OTHER;
    case (in_char_in)
      8'h70: begin tok_in.cls = cldp_pkg::TK_LETTER; tok_in.code = cldp_pkg::CMD_P; end
      8'h42: begin tok_in.cls = cldp_pkg::TK_LETTER; tok_in.code = cldp_pkg::CMD_BB; end
      8'h49: begin tok_in.cls = cldp_pkg::TK_LETTER; tok_in.code = cldp_pkg::CMD_I; end
      8'h66: begin tok_in.cls = cldp_pkg::TK_LETTER; tok_in.code = cldp_pkg::CMD_F; end
      8'h67: begin tok_in.cls = cldp_pkg::TK_LETTER; tok_in.code = cldp_pkg::CMD_G; end
      8'h71: begin tok_in.cls = cldp_pkg::TK_LETTER; tok_in.code = cldp_pkg::CMD_Q; end
      8'h6d: begin tok_in.cls = cldp_pkg::TK_LETTER; tok_in.code = cldp_pkg::CMD_M; end
      8'h62: begin tok_in.cls = cldp_pkg::TK_LETTER; tok_in.code = cldp_pkg::CMD_B; end
      default: begin
        if (in_char_in == cldp_pkg::CH_NEWLINE) begin
          tok_in.cls = cldp_pkg::TK_NEWLINE;
        end else if (in_char_in == cldp_pkg::CH_SPACE ||
                     (in_char_in >= cldp_pkg::CH_TAB && in_char_in <= cldp_pkg::CH_CR)) begin
          tok_in.cls = cldp_pkg::TK_SPACE;
        end else if (in_char_in >= cldp_pkg::CH_ZERO && in_char_in <= cldp_pkg::CH_NINE) begin
          tok_in.cls = cldp_pkg::TK_DIGIT;
        end
      end
    endcase
  end

  cldp_fifo #(
    .WIDTH($bits(cldp_pkg::token_t))
  ) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (tok_in),
    .full  (in_full),
    .pop   (tok_pop),
    .rdata (tok_raw),
    .empty (tok_empty)
  );

  assign tok = cldp_pkg::token_t'(tok_raw);

endmodule

// ===== rtl/cldp_back.sv =====
// cldp_back: runs the line parser on queued tokens and builds one result per line
// depends on cldp_pkg
module cldp_back #(
  parameter int MAX_ARGS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cldp_pkg::token_t      tok,
  input  logic                  tok_empty,
  output logic                  tok_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output cldp_pkg::result_t     res,
  input  cldp_pkg::term_cfg_t   term
);

  localparam int CW = $clog2(MAX_ARGS + 1);
  localparam int AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
  localparam int AV = cldp_pkg::ARG_W;

  typedef enum logic [2:0] {
    PH_LETTER,
    PH_SEP,
    PH_GAP,
    PH_NUM,
    PH_ZERO
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic                         err_r, err_nxt;
  logic [cldp_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [CW-1:0]                args_r, args_nxt;
  logic [AV-1:0]                acc_r, acc_nxt;
  logic [AV-1:0]                store_r [MAX_ARGS];
  logic [AV-1:0]                store_nxt [MAX_ARGS];
  logic [AV-1:0]                tap [cldp_pkg::NUM_OUT_ARGS];
  logic [AV-1:0]                fin_arg [cldp_pkg::NUM_OUT_ARGS];
  logic [cldp_pkg::NEED_W-1:0]  fin_cnt;
  logic                         closing;
  logic                         ok;
  logic [AV+3:0]                prod;

  for (genvar k = 0; k < cldp_pkg::NUM_OUT_ARGS; k++) begin : g_tap
    if (k < MAX_ARGS) begin : g_on
      assign tap[k] = store_r[k];
    end else begin : g_off
      assign tap[k] = '0;
    end
  end

  assign closing = (phase_r == PH_NUM) || (phase_r == PH_ZERO);
  assign prod    = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + (AV+4)'(tok.digit);

  always_comb begin
    for (int k = 0; k < cldp_pkg::NUM_OUT_ARGS; k++) begin
      fin_arg[k] = tap[k];
      if (closing && k < MAX_ARGS &&
          cldp_pkg::NEED_W'(args_r) == cldp_pkg::NEED_W'(k)) begin
        fin_arg[k] = acc_r;
      end
    end
    fin_cnt = cldp_pkg::NEED_W'(args_r) + (closing ? 4'd1 : 4'd0);
    ok = !err_r && (phase_r != PH_LETTER) && (fin_cnt == cldp_pkg::need_count(cmd_r));
    if (cmd_r == cldp_pkg::CMD_I) begin
      if (fin_arg[0] > AV'(term.cols) || term.cols < cldp_pkg::MIN_BOARD_COLS ||
          fin_arg[1] > AV'(term.rows)) begin
        ok = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    err_nxt   = err_r;
    cmd_nxt   = cmd_r;
    args_nxt  = args_r;
    acc_nxt   = acc_r;
    store_nxt = store_r;
    res_push  = 1'b0;
    res       = '0;
    tok_pop   = !tok_empty && (tok.cls != cldp_pkg::TK_NEWLINE || !res_full);

    if (tok_pop) begin
      if (tok.cls == cldp_pkg::TK_NEWLINE) begin
        res_push = 1'b1;
        if (ok) begin
          res.line_valid   = 1'b1;
          res.command_code = cmd_r;
          res.arg_count    = fin_cnt[cldp_pkg::CNT_W-1:0];
          for (int k = 0; k < cldp_pkg::NUM_OUT_ARGS; k++) begin
            res.args[k] = fin_arg[k];
          end
        end
        phase_nxt = PH_LETTER;
        err_nxt   = 1'b0;
        cmd_nxt   = cldp_pkg::CMD_P;
        args_nxt  = '0;
        acc_nxt   = '0;
        for (int k = 0; k < MAX_ARGS; k++) begin
          store_nxt[k] = '0;
        end
      end else if (!err_r) begin
        case (phase_r)
          PH_LETTER: begin
            if (tok.cls == cldp_pkg::TK_LETTER) begin
              cmd_nxt   = tok.code;
              phase_nxt = PH_SEP;
            end else begin
              err_nxt = 1'b1;
            end
          end
          PH_SEP: begin
            if (tok.cls == cldp_pkg::TK_SPACE) phase_nxt = PH_GAP;
            else err_nxt = 1'b1;
          end
          PH_GAP: begin
            if (tok.cls == cldp_pkg::TK_SPACE) begin
              phase_nxt = PH_GAP;
            end else if (tok.cls != cldp_pkg::TK_DIGIT || args_r >= CW'(MAX_ARGS)) begin
              err_nxt = 1'b1;
            end else begin
              acc_nxt   = AV'(tok.digit);
              phase_nxt = (tok.digit == '0) ? PH_ZERO : PH_NUM;
            end
          end
          PH_ZERO, PH_NUM: begin
            if (tok.cls == cldp_pkg::TK_SPACE) begin
              store_nxt[args_r[AW-1:0]] = acc_r;
              args_nxt  = args_r + CW'(1);
              acc_nxt   = '0;
              phase_nxt = PH_GAP;
            end else if (tok.cls == cldp_pkg::TK_DIGIT && phase_r == PH_NUM) begin
              acc_nxt = prod[AV-1:0];
              if (prod[AV+3:AV] != '0) err_nxt = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
          end
          default: err_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LETTER;
      err_r   <= 1'b0;
      cmd_r   <= cldp_pkg::CMD_P;
      args_r  <= '0;
      acc_r   <= '0;
      for (int k = 0; k < MAX_ARGS; k++) begin
        store_r[k] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      cmd_r   <= cmd_nxt;
      args_r  <= args_nxt;
      acc_r   <= acc_nxt;
      store_r <= store_nxt;
    end
  end

endmodule

// ===== rtl/command_line_decimal_parser_unit.sv =====
// command_line_decimal_parser_unit: top level of the command line parser
// depends on cldp_pkg, cldp_front, cldp_back and cldp_fifo
//
// One character of a request line enters per transaction on the input queue
// side (in_push / in_full). A newline closes the line and yields one result
// on the output queue side (out_empty / out_pop): validity, command code,
// argument count and four 32-bit arguments, all zero when the line is bad.
// Other characters yield no result.
// A front stage classifies each character and puts a token into a two-entry
// queue; a back stage takes one token per cycle, but holds a newline while
// the result queue is full, updates the parser state (multiply-by-ten
// accumulate) and writes results into a two-entry queue. Throughput is one
// character per cycle while results are popped. A result is visible once
// its newline token has left the token queue and entered the result queue.
// When the receiver stops popping, the result queue fills, the back stage
// holds newline tokens, the token queue fills and in_full rises; no
// character or result is dropped. Synchronous active-low reset empties both
// queues, clears the parser to expect a command letter and loads terminal
// size 80 columns by 24 rows. The cfg port writes terminal columns (index 0)
// or rows (index 1); write it only while no line is in progress.
module command_line_decimal_parser_unit #(
  parameter int MAX_ARGS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic [cldp_pkg::CHAR_W-1:0]      in_char_in,
  output logic                             in_full,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic                             out_line_valid,
  output logic [cldp_pkg::CMD_W-1:0]       out_command_code,
  output logic [cldp_pkg::CNT_W-1:0]       out_arg_count,
  output logic [cldp_pkg::ARG_W-1:0]       out_arg_zero,
  output logic [cldp_pkg::ARG_W-1:0]       out_arg_one,
  output logic [cldp_pkg::ARG_W-1:0]       out_arg_two,
  output logic [cldp_pkg::ARG_W-1:0]       out_arg_three,
  input  logic                             cfg_wr_en,
  input  logic [cldp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cldp_pkg::TERM_W-1:0]      cfg_data
);

  cldp_pkg::term_cfg_t  term_r;
  cldp_pkg::token_t     tok;
  logic                 tok_empty;
  logic                 tok_pop;
  logic                 res_full;
  logic                 res_push;
  cldp_pkg::result_t    res;
  cldp_pkg::result_t    head;
  logic [$bits(cldp_pkg::result_t)-1:0] head_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r.cols <= cldp_pkg::TERM_COLS_RST;
      term_r.rows <= cldp_pkg::TERM_ROWS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cldp_pkg::REG_TERM_COLS: term_r.cols <= cfg_data;
        cldp_pkg::REG_TERM_ROWS: term_r.rows <= cfg_data;
        default: term_r <= term_r;
      endcase
    end
  end

  cldp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_char_in (in_char_in),
    .in_full    (in_full),
    .tok        (tok),
    .tok_empty  (tok_empty),
    .tok_pop    (tok_pop)
  );

  cldp_back #(
    .MAX_ARGS(MAX_ARGS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .term      (term_r)
  );

  cldp_fifo #(
    .WIDTH($bits(cldp_pkg::result_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (head_raw),
    .empty (out_empty)
  );

  assign head             = cldp_pkg::result_t'(head_raw);
  assign out_line_valid   = head.line_valid;
  assign out_command_code = head.command_code;
  assign out_arg_count    = head.arg_count;
  assign out_arg_zero     = head.args[0];
  assign out_arg_one      = head.args[1];
  assign out_arg_two      = head.args[2];
  assign out_arg_three    = head.args[3];

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_bad_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_line_valid) |->
      (out_command_code == cldp_pkg::CMD_P && out_arg_count == '0 &&
       out_arg_zero == '0 && out_arg_one == '0 &&
       out_arg_two == '0 && out_arg_three == '0))
    else $error("invalid line carries nonzero fields");

  a_board_width: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_line_valid && out_command_code == cldp_pkg::CMD_I) |->
      (term_r.cols >= cldp_pkg::MIN_BOARD_COLS &&
       out_arg_zero <= cldp_pkg::ARG_W'(term_r.cols) &&
       out_arg_one <= cldp_pkg::ARG_W'(term_r.rows)))
    else $error("board size outside terminal accepted");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_line_valid) |->
      (32'(out_arg_count) <= 32'(MAX_ARGS)))
    else $error("argument count above limit");
`endif

endmodule
